### rtl/opd_pkg.sv
// ----------------------------------------------------------------------------
// opd_pkg
// types, constants and fixed-point helpers of the orbit plant derivatives unit
// ----------------------------------------------------------------------------
package opd_pkg;

    localparam int FRAC_BITS = 32;
    localparam int DIV_LAT   = 64;
    localparam int SQ_LAT    = (64 + FRAC_BITS + 1) / 2;
    localparam int RAD_W     = 2 * SQ_LAT;

    localparam logic [63:0] ONE_Q     = 64'd1 << FRAC_BITS;
    localparam logic [63:0] CAPTURE_Q = ((64'd205 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [46:0] ACCEL_LIMIT_RESET = 47'd85899346;
    localparam logic [63:0] MAX47 = (64'd1 << 47) - 64'd1;

    typedef struct packed {
        logic [46:0]        radius;
        logic signed [47:0] radial_velocity;
        logic signed [47:0] ang_momentum;
        logic signed [47:0] thrust_radial;
        logic signed [47:0] thrust_tangential;
    } opd_in_t;

    typedef struct packed {
        logic signed [47:0] radius_rate;
        logic signed [47:0] radial_accel;
        logic signed [47:0] angle_rate;
        logic signed [47:0] momentum_rate;
        logic [46:0]        clock_rate;
        logic [46:0]        fuel_rate;
        logic               captured;
    } opd_out_t;

    typedef struct packed {
        logic        neg;
        logic [47:0] mag;
    } thr_t;

    typedef struct packed {
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } mul_parts_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] quo;
        logic [63:0] den;
        logic        ovf;
    } div_st_t;

    typedef struct packed {
        logic [SQ_LAT+1:0] rem;
        logic [RAD_W-1:0]  rad;
        logic [SQ_LAT-1:0] root;
    } sq_st_t;

    function automatic mul_parts_t mul_parts(input logic [63:0] a, input logic [63:0] b);
        mul_parts_t p;
        p.p00 = a[31:0] * b[31:0];
        p.p01 = a[31:0] * b[63:32];
        p.p10 = a[63:32] * b[31:0];
        p.p11 = a[63:32] * b[63:32];
        return p;
    endfunction

    function automatic logic [63:0] mul_join(input mul_parts_t p);
        logic [127:0] s;
        s = {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
            + {p.p11, 64'd0};
        if (|s[127:64+FRAC_BITS])
            return '1;
        return s[63+FRAC_BITS:FRAC_BITS];
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] divq_hi(input logic [63:0] a);
        return a >> (64 - FRAC_BITS);
    endfunction

    function automatic logic [63:0] divq_lo(input logic [63:0] a);
        return a << FRAC_BITS;
    endfunction

    function automatic logic [47:0] signed_out(input logic neg, input logic [63:0] mag);
        logic [63:0] m;
        m = mag;
        if (neg) begin
            if (m > (64'd1 << 47))
                m = 64'd1 << 47;
            return 48'd0 - m[47:0];
        end
        if (m > MAX47)
            m = MAX47;
        return m[47:0];
    endfunction

    function automatic thr_t clamp_thrust(input logic [47:0] a, input logic [46:0] lim);
        logic signed [48:0] sa;
        logic signed [48:0] sl;
        logic signed [48:0] c;
        logic [48:0]        nc;
        thr_t t;
        sa = signed'({a[47], a});
        sl = signed'({2'b00, lim});
        if (sa > sl)
            c = sl;
        else if (sa < -sl)
            c = -sl;
        else
            c = sa;
        nc = -c;
        t.neg = c[48];
        t.mag = c[48] ? nc[47:0] : c[47:0];
        return t;
    endfunction

    function automatic logic [47:0] mag48(input logic [47:0] x);
        logic [47:0] n;
        n = 48'd0 - x;
        return x[47] ? n : x;
    endfunction

    function automatic div_st_t div_step(input div_st_t s);
        logic [64:0] t;
        div_st_t o;
        o = s;
        t = {s.rem, s.lo[63]};
        o.lo = s.lo << 1;
        if (t >= {1'b0, s.den}) begin
            t = t - {1'b0, s.den};
            o.quo = {s.quo[62:0], 1'b1};
        end
        else begin
            o.quo = {s.quo[62:0], 1'b0};
        end
        o.rem = t[63:0];
        return o;
    endfunction

    function automatic sq_st_t sq_step(input sq_st_t s);
        logic [SQ_LAT+1:0] t;
        logic [SQ_LAT+1:0] trial;
        sq_st_t o;
        o = s;
        t = {s.rem[SQ_LAT-1:0], s.rad[RAD_W-1:RAD_W-2]};
        trial = {s.root, 2'b01};
        o.rad = s.rad << 2;
        if (t >= trial) begin
            o.rem = t - trial;
            o.root = {s.root[SQ_LAT-2:0], 1'b1};
        end
        else begin
            o.rem = t;
            o.root = {s.root[SQ_LAT-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### rtl/opd_div.sv
// ----------------------------------------------------------------------------
// opd_div
// pipelined restoring divider, 128 by 64 bits, one quotient bit per stage
// ----------------------------------------------------------------------------
module opd_div
    import opd_pkg::*;
(
    input  logic        clk,
    input  logic [63:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [63:0] den,
    output logic [63:0] quo
);

    div_st_t st_in;
    div_st_t st_reg [DIV_LAT];

    always_comb
    begin
        st_in.rem = num_hi;
        st_in.lo  = num_lo;
        st_in.quo = '0;
        st_in.den = den;
        st_in.ovf = (den == '0) || (num_hi >= den);
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= div_step(st_in);
        for (int i = 1; i < DIV_LAT; i++)
        begin
            st_reg[i] <= div_step(st_reg[i-1]);
        end
    end

    assign quo = st_reg[DIV_LAT-1].ovf ? '1 : st_reg[DIV_LAT-1].quo;

endmodule

### rtl/opd_sqrt.sv
// ----------------------------------------------------------------------------
// opd_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module opd_sqrt
    import opd_pkg::*;
(
    input  logic              clk,
    input  logic [RAD_W-1:0]  rad,
    output logic [SQ_LAT-1:0] root
);

    sq_st_t st_in;
    sq_st_t st_reg [SQ_LAT];

    always_comb
    begin
        st_in.rem  = '0;
        st_in.rad  = rad;
        st_in.root = '0;
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= sq_step(st_in);
        for (int i = 1; i < SQ_LAT; i++)
        begin
            st_reg[i] <= sq_step(st_reg[i-1]);
        end
    end

    assign root = st_reg[SQ_LAT-1].root;

endmodule

### rtl/orbit_plant_derivatives_unit.sv
// ----------------------------------------------------------------------------
// orbit_plant_derivatives_unit
// state derivatives of a thrust-driven particle near a black hole, Q16.32
// ----------------------------------------------------------------------------
// A new word may be started in every cycle: busy stays low and cfg_ready stays
// high. Each result shows on result for one cycle with result_valid, after
// passing two 64-stage dividers and a 48-stage root in series, plus multiply
// and add stages; the receiver cannot stall the unit.
module orbit_plant_derivatives_unit
    import opd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  opd_in_t     item,
    output logic        result_valid,
    output opd_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [46:0] cfg_data
);

    localparam int T2 = DIV_LAT + 2;
    localparam int T3 = T2 + DIV_LAT;
    localparam int T4 = T2 + 4 + SQ_LAT;
    localparam int T5 = T4 + DIV_LAT;
    localparam int OUT_LAT = T5 + 2;

    typedef struct packed {
        logic        captured;
        logic [46:0] r;
        logic [47:0] v;
        logic        l_neg;
        logic [47:0] l_mag;
        logic        ar_neg;
        logic [47:0] arm;
        logic        aphi_neg;
        logic [47:0] aphim;
    } side_t;

    typedef struct packed {
        logic [63:0] u2;
        logic        gneg;
        logic [63:0] gmag;
    } grav_t;

    logic [46:0] limit_reg;
    logic        vld_reg [T5+1];
    logic        out_vld_reg;
    side_t       side_in;
    side_t       side_reg [T5+1];
    thr_t        thr_r;
    thr_t        thr_t_in;

    logic [63:0] u_w, q_w, t1_w, ang_w, clk_w;
    logic [SQ_LAT-1:0] root_w;
    logic [63:0] s_w;

    mul_parts_t  uu_parts_reg, qq_parts_reg, vv_parts_reg, fs_parts_reg;
    mul_parts_t  term_parts_reg, mom_parts_reg;
    logic [63:0] u_d1_reg, u_d2_reg, q_d1_reg, q_d2_reg;
    logic [63:0] u2_reg, q2_reg, s1_reg, vv_reg, vv_d_reg, fs_reg, e2_reg;
    logic [63:0] term_reg, pos_reg, neg_reg, mom_reg;
    logic [63:0] f_dly_reg [SQ_LAT+4];
    grav_t       g_dly_reg [DIV_LAT];
    grav_t       rg_d1_reg, rg_d2_reg;
    logic [47:0] rad_dly_reg [SQ_LAT+1];
    logic [63:0] ang_dly_reg [SQ_LAT+4];
    opd_out_t    out_reg;

    logic [63:0] three_u;
    logic [63:0] pos_next, neg_next;
    logic [48:0] fuel_sum;
    side_t       side_fin;
    opd_out_t    out_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ACCEL_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // input word
    always_comb
    begin
        thr_r    = clamp_thrust(item.thrust_radial, limit_reg);
        thr_t_in = clamp_thrust(item.thrust_tangential, limit_reg);
        side_in.captured = {17'd0, item.radius} <= CAPTURE_Q;
        side_in.r        = item.radius;
        side_in.v        = item.radial_velocity;
        side_in.l_neg    = item.ang_momentum[47];
        side_in.l_mag    = mag48(item.ang_momentum);
        side_in.ar_neg   = thr_r.neg;
        side_in.arm      = thr_r.mag;
        side_in.aphi_neg = thr_t_in.neg;
        side_in.aphim    = thr_t_in.mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= T5; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i <= T5; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_vld_reg <= vld_reg[T5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i <= T5; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // u = 1/r and q = |L|/r
    opd_div u_div_u (
        .clk    (clk),
        .num_hi (divq_hi(ONE_Q)),
        .num_lo (divq_lo(ONE_Q)),
        .den    ({17'd0, side_reg[0].r}),
        .quo    (u_w)
    );

    opd_div u_div_q (
        .clk    (clk),
        .num_hi (divq_hi({16'd0, side_reg[0].l_mag})),
        .num_lo (divq_lo({16'd0, side_reg[0].l_mag})),
        .den    ({17'd0, side_reg[0].r}),
        .quo    (q_w)
    );

    // t1 = q^2/r and angle rate q/r
    opd_div u_div_t1 (
        .clk    (clk),
        .num_hi (divq_hi(q2_reg)),
        .num_lo (divq_lo(q2_reg)),
        .den    ({17'd0, side_reg[T2].r}),
        .quo    (t1_w)
    );

    opd_div u_div_ang (
        .clk    (clk),
        .num_hi (divq_hi(q_d2_reg)),
        .num_lo (divq_lo(q_d2_reg)),
        .den    ({17'd0, side_reg[T2].r}),
        .quo    (ang_w)
    );

    opd_sqrt u_sqrt (
        .clk  (clk),
        .rad  (RAD_W'({e2_reg, {FRAC_BITS{1'b0}}})),
        .root (root_w)
    );

    assign s_w = 64'(root_w);

    opd_div u_div_clk (
        .clk    (clk),
        .num_hi (divq_hi(s_w)),
        .num_lo (divq_lo(s_w)),
        .den    (f_dly_reg[SQ_LAT+3]),
        .quo    (clk_w)
    );

    assign three_u = (u_d2_reg << 1) + u_d2_reg;

    always_comb
    begin
        pos_next = '0;
        neg_next = rg_d2_reg.u2;
        if (rg_d2_reg.gneg)
            neg_next = sat_add(neg_next, term_reg);
        else
            pos_next = sat_add(pos_next, term_reg);
        if (side_reg[T3+2].ar_neg)
            neg_next = sat_add(neg_next, {16'd0, side_reg[T3+2].arm});
        else
            pos_next = sat_add(pos_next, {16'd0, side_reg[T3+2].arm});
    end

    always_ff @(posedge clk)
    begin
        uu_parts_reg <= mul_parts(u_w, u_w);
        qq_parts_reg <= mul_parts(q_w, q_w);
        u_d1_reg     <= u_w;
        q_d1_reg     <= q_w;

        u2_reg   <= mul_join(uu_parts_reg);
        q2_reg   <= mul_join(qq_parts_reg);
        u_d2_reg <= u_d1_reg;
        q_d2_reg <= q_d1_reg;

        f_dly_reg[0] <= ONE_Q - (u_d2_reg << 1);
        for (int i = 1; i < SQ_LAT + 4; i++)
        begin
            f_dly_reg[i] <= f_dly_reg[i-1];
        end
        s1_reg       <= sat_add(ONE_Q, q2_reg);
        vv_parts_reg <= mul_parts({16'd0, mag48(side_reg[T2].v)},
                                  {16'd0, mag48(side_reg[T2].v)});
        g_dly_reg[0].u2   <= u2_reg;
        g_dly_reg[0].gneg <= three_u > ONE_Q;
        g_dly_reg[0].gmag <= (three_u > ONE_Q) ? three_u - ONE_Q : ONE_Q - three_u;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            g_dly_reg[i] <= g_dly_reg[i-1];
        end

        fs_parts_reg <= mul_parts(f_dly_reg[0], s1_reg);
        vv_reg       <= mul_join(vv_parts_reg);
        fs_reg       <= mul_join(fs_parts_reg);
        vv_d_reg     <= vv_reg;
        e2_reg       <= sat_add(vv_d_reg, fs_reg);

        term_parts_reg <= mul_parts(t1_w, g_dly_reg[DIV_LAT-1].gmag);
        rg_d1_reg      <= g_dly_reg[DIV_LAT-1];
        term_reg       <= mul_join(term_parts_reg);
        rg_d2_reg      <= rg_d1_reg;
        pos_reg        <= pos_next;
        neg_reg        <= neg_next;
        rad_dly_reg[0] <= (pos_reg >= neg_reg) ? signed_out(1'b0, pos_reg - neg_reg)
                                               : signed_out(1'b1, neg_reg - pos_reg);
        for (int i = 1; i <= SQ_LAT; i++)
        begin
            rad_dly_reg[i] <= rad_dly_reg[i-1];
        end

        ang_dly_reg[0] <= ang_w;
        for (int i = 1; i < SQ_LAT + 4; i++)
        begin
            ang_dly_reg[i] <= ang_dly_reg[i-1];
        end

        mom_parts_reg <= mul_parts({17'd0, side_reg[T5-2].r}, {16'd0, side_reg[T5-2].aphim});
        mom_reg       <= mul_join(mom_parts_reg);

        out_reg <= out_next;
    end

    // output word
    always_comb
    begin
        side_fin = side_reg[T5];
        fuel_sum = {1'b0, side_fin.arm} + {1'b0, side_fin.aphim};
        out_next = '0;
        out_next.captured = 1'b1;
        if (!side_fin.captured)
        begin
            out_next.captured      = 1'b0;
            out_next.radius_rate   = side_fin.v;
            out_next.radial_accel  = rad_dly_reg[SQ_LAT];
            out_next.angle_rate    = signed_out(side_fin.l_neg, ang_dly_reg[SQ_LAT+3]);
            out_next.momentum_rate = signed_out(side_fin.aphi_neg, mom_reg);
            out_next.clock_rate    = (clk_w > MAX47) ? MAX47[46:0] : clk_w[46:0];
            out_next.fuel_rate     = ({15'd0, fuel_sum} > MAX47) ? MAX47[46:0]
                                                                : fuel_sum[46:0];
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, OUT_LAT))
        else $error("result without a started word");

    a_captured_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.captured |->
            result.radius_rate == '0 && result.radial_accel == '0 &&
            result.angle_rate == '0 && result.momentum_rate == '0 &&
            result.clock_rate == '0 && result.fuel_rate == '0)
        else $error("captured word with nonzero derivative");

    a_clock_positive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.captured |-> result.clock_rate != '0)
        else $error("zero clock rate outside capture");
`endif

endmodule
